// File: src/vgmpsg_pkg.sv
package vgmpsg_pkg;

   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned KIND_W       = 2;
   localparam int unsigned WAIT_W       = 16;
   localparam int unsigned OFFSET_W     = 32;
   localparam int unsigned LOOPS_W      = 8;
   localparam int unsigned CSR_INDEX_W  = 1;
   localparam int unsigned RSP_DATA_W   = 2 * BYTE_W + WAIT_W + OFFSET_W;

   // Command bytes of the stream.
   localparam logic [BYTE_W-1:0] CMD_PSG_WRITE = 8'hA0;
   localparam logic [BYTE_W-1:0] CMD_WAIT_N    = 8'h61;
   localparam logic [BYTE_W-1:0] CMD_WAIT_NTSC = 8'h62;
   localparam logic [BYTE_W-1:0] CMD_WAIT_PAL  = 8'h63;
   localparam logic [BYTE_W-1:0] CMD_END       = 8'h66;
   localparam logic [BYTE_W-1:0] CMD_SHORT_LO  = 8'h70;
   localparam logic [BYTE_W-1:0] CMD_SHORT_HI  = 8'h7F;

   localparam logic [WAIT_W-1:0]   WAIT_NTSC_SAMPLES = 16'd735;
   localparam logic [WAIT_W-1:0]   WAIT_PAL_SAMPLES  = 16'd882;
   localparam logic [OFFSET_W-1:0] LOOP_BASE         = 32'h0000_001C;
   localparam logic [LOOPS_W-1:0]  LOOP_COUNT_MAX    = 8'hFF;

   localparam logic [OFFSET_W-1:0] LOOP_OFFSET_RESET = '0;
   localparam logic [LOOPS_W-1:0]  MAX_LOOPS_RESET   = 8'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_OFFSET = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LOOPS   = 1'b1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WAIT    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd3;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_PSG_REG = 5'b00010,
      PH_PSG_VAL = 5'b00100,
      PH_WAIT_LO = 5'b01000,
      PH_WAIT_HI = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type           phase;
      logic [BYTE_W-1:0]   first_operand;
      logic [LOOPS_W-1:0]  loop_count;
   } parse_state_type;

   typedef struct packed {
      logic                 valid;
      logic [KIND_W-1:0]    kind;
      logic [BYTE_W-1:0]    reg_addr;
      logic [BYTE_W-1:0]    reg_value;
      logic [WAIT_W-1:0]    wait_samples;
      logic [OFFSET_W-1:0]  restart_offset;
   } result_type;

endpackage

// File: src/vgmpsg_decode.sv
module vgmpsg_decode (
   input  vgmpsg_pkg::parse_state_type          state_cur,
   input  logic [vgmpsg_pkg::BYTE_W-1:0]        stream_byte,
   input  logic [vgmpsg_pkg::OFFSET_W-1:0]      loop_offset,
   input  logic [vgmpsg_pkg::LOOPS_W-1:0]       max_loops,
   output vgmpsg_pkg::parse_state_type          state_nxt,
   output vgmpsg_pkg::result_type               result
);

   logic [vgmpsg_pkg::LOOPS_W-1:0] loop_next;
   logic                           loop_done;

   assign loop_next = state_cur.loop_count + 1'b1;
   // A saturated count wraps on increment, so it must end the song explicitly.
   assign loop_done = (state_cur.loop_count == vgmpsg_pkg::LOOP_COUNT_MAX) ||
                      (loop_next >= max_loops);

   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      case (state_cur.phase)
         vgmpsg_pkg::PH_PSG_REG: begin
            state_nxt.first_operand = stream_byte;
            state_nxt.phase         = vgmpsg_pkg::PH_PSG_VAL;
         end
         vgmpsg_pkg::PH_PSG_VAL: begin
            state_nxt.phase  = vgmpsg_pkg::PH_IDLE;
            result.valid     = 1'b1;
            result.kind      = vgmpsg_pkg::KIND_WRITE;
            result.reg_addr  = state_cur.first_operand;
            result.reg_value = stream_byte;
         end
         vgmpsg_pkg::PH_WAIT_LO: begin
            state_nxt.first_operand = stream_byte;
            state_nxt.phase         = vgmpsg_pkg::PH_WAIT_HI;
         end
         vgmpsg_pkg::PH_WAIT_HI: begin
            state_nxt.phase     = vgmpsg_pkg::PH_IDLE;
            result.valid        = 1'b1;
            result.kind         = vgmpsg_pkg::KIND_WAIT;
            result.wait_samples = {stream_byte, state_cur.first_operand};
         end
         default: begin
            state_nxt.phase = vgmpsg_pkg::PH_IDLE;
            if (stream_byte == vgmpsg_pkg::CMD_PSG_WRITE) begin
               state_nxt.phase = vgmpsg_pkg::PH_PSG_REG;
            end else if (stream_byte == vgmpsg_pkg::CMD_WAIT_N) begin
               state_nxt.phase = vgmpsg_pkg::PH_WAIT_LO;
            end else if (stream_byte == vgmpsg_pkg::CMD_WAIT_NTSC) begin
               result.valid        = 1'b1;
               result.kind         = vgmpsg_pkg::KIND_WAIT;
               result.wait_samples = vgmpsg_pkg::WAIT_NTSC_SAMPLES;
            end else if (stream_byte == vgmpsg_pkg::CMD_WAIT_PAL) begin
               result.valid        = 1'b1;
               result.kind         = vgmpsg_pkg::KIND_WAIT;
               result.wait_samples = vgmpsg_pkg::WAIT_PAL_SAMPLES;
            end else if (stream_byte inside {[vgmpsg_pkg::CMD_SHORT_LO:
                                               vgmpsg_pkg::CMD_SHORT_HI]}) begin
               result.valid        = 1'b1;
               result.kind         = vgmpsg_pkg::KIND_WAIT;
               result.wait_samples = {12'd0, stream_byte[3:0]} + 16'd1;
            end else if (stream_byte == vgmpsg_pkg::CMD_END) begin
               result.valid = 1'b1;
               if ((loop_offset == '0) || loop_done) begin
                  state_nxt.loop_count = '0;
                  result.kind          = vgmpsg_pkg::KIND_END;
               end else begin
                  state_nxt.loop_count  = loop_next;
                  result.kind           = vgmpsg_pkg::KIND_RESTART;
                  result.restart_offset = loop_offset + vgmpsg_pkg::LOOP_BASE;
               end
            end
         end
      endcase
   end

endmodule

// File: src/vgm_psg_command_parser.sv
// VGM command stream parser for the PSG subset.
// The req_ channel carries one stream byte per transfer; the rsp_ channel
// carries decoded commands: rsp_tuser is the kind (register write, wait,
// song end, restart at loop point) and rsp_tdata the operands, unused ones
// zero. Operand bytes and unknown commands produce no response transfer.
// Each byte goes through an input register, then through the decoder into
// the output register, which drives rsp_tvalid. One byte per cycle is
// accepted when rsp_tready stays high; the throughput is set by the parse
// state update, whose next state the decoder computes for each byte.
// When the receiver stalls, the output register holds its response and the
// input register still takes one more byte; after that req_tready drops
// until the response is taken.
// The csr_ port writes loop_offset (index 0) and max_loops (index 1);
// write it only while no byte is in flight.
// Reset is synchronous: the parser returns to expecting a command byte, the
// loop count clears, loop_offset becomes 0 and max_loops becomes 2.
module vgm_psg_command_parser (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [vgmpsg_pkg::BYTE_W-1:0]            req_tdata,   // stream_byte
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // reg_addr, reg_value, wait_samples, restart_offset
   output logic [vgmpsg_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [vgmpsg_pkg::KIND_W-1:0]            rsp_tuser,   // kind
   input  logic                                     csr_we,
   input  logic [vgmpsg_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [vgmpsg_pkg::OFFSET_W-1:0]          csr_wdata
);

   logic [vgmpsg_pkg::OFFSET_W-1:0] loop_offset_ff;
   logic [vgmpsg_pkg::LOOPS_W-1:0]  max_loops_ff;

   logic                            in_valid_ff;
   logic [vgmpsg_pkg::BYTE_W-1:0]   in_byte_ff;

   vgmpsg_pkg::parse_state_type     state_ff;
   vgmpsg_pkg::parse_state_type     state_in;
   vgmpsg_pkg::result_type          result;

   logic                            rsp_valid_ff;
   logic [vgmpsg_pkg::KIND_W-1:0]   rsp_kind_ff;
   logic [vgmpsg_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic out_free;
   logic advance;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_offset_ff <= vgmpsg_pkg::LOOP_OFFSET_RESET;
         max_loops_ff   <= vgmpsg_pkg::MAX_LOOPS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            vgmpsg_pkg::CSR_LOOP_OFFSET: loop_offset_ff <= csr_wdata;
            vgmpsg_pkg::CSR_MAX_LOOPS:   max_loops_ff   <= csr_wdata[vgmpsg_pkg::LOOPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   vgmpsg_decode u_decode (
      .state_cur   (state_ff),
      .stream_byte (in_byte_ff),
      .loop_offset (loop_offset_ff),
      .max_loops   (max_loops_ff),
      .state_nxt   (state_in),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= vgmpsg_pkg::PH_IDLE;
         state_ff.first_operand <= '0;
         state_ff.loop_count    <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // The output register loads whenever it is free; a byte without a
   // response simply leaves it empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid && out_free) begin
         rsp_kind_ff <= result.kind;
         rsp_data_ff <= {result.restart_offset, result.wait_samples,
                         result.reg_value, result.reg_addr};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
